### hdl/jdcal_pkg.sv
// ----------------------------------------------------------------------------
// jdcal_pkg: shared types and constants for the day-number-to-date converter
// Field widths, reciprocal constants for the three divisions by constants,
// and the month-start table.
// ----------------------------------------------------------------------------
package jdcal_pkg;

   // Port field widths
   localparam int JD_W    = 23;
   localparam int YEAR_W  = 15;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;

   // First day number of the Gregorian calendar (15 Oct 1582)
   localparam logic [JD_W-1:0] GREG_START = 23'd2299161;

   // alpha = (4*J - ALPHA_BIAS) / ALPHA_DIV, by reciprocal multiply.
   // Rounded-up reciprocal with shift = width + clog2(divisor) is exact for
   // every dividend of that width.
   localparam int     ALPHA_X_W   = JD_W + 2;
   localparam logic [ALPHA_X_W-1:0] ALPHA_BIAS = 25'd7468865;
   localparam longint ALPHA_DIV   = 146097;
   localparam int     ALPHA_SHIFT = ALPHA_X_W + $clog2(ALPHA_DIV);
   localparam int     ALPHA_MUL_W = ALPHA_SHIFT - $clog2(ALPHA_DIV) + 1;
   localparam longint ALPHA_MUL   =
      ((longint'(1) << ALPHA_SHIFT) + ALPHA_DIV - 1) / ALPHA_DIV;
   localparam logic [ALPHA_MUL_W-1:0] ALPHA_MUL_V = ALPHA_MUL_W'(ALPHA_MUL);
   localparam int     ALPHA_P_W   = ALPHA_X_W + ALPHA_MUL_W;
   localparam int     ALPHA_W     = 8;

   // b = a + B_OFFSET; y = Y_SCALE*b - Y_OFFSET
   localparam int B_W       = JD_W + 1;
   localparam int B_OFFSET  = 1524;
   localparam int Y_W       = 30;
   localparam int Y_FULL_W  = B_W + 7;
   localparam int Y_SCALE   = 100;
   localparam int Y_OFFSET  = 12210;

   // c = y / C_DIV
   localparam longint C_DIV   = 36525;
   localparam int     C_SHIFT = Y_W + $clog2(C_DIV);
   localparam int     C_MUL_W = C_SHIFT - $clog2(C_DIV) + 1;
   localparam longint C_MUL   = ((longint'(1) << C_SHIFT) + C_DIV - 1) / C_DIV;
   localparam logic [C_MUL_W-1:0] C_MUL_V = C_MUL_W'(C_MUL);
   localparam int     C_P_W   = Y_W + C_MUL_W;
   localparam int     C_W     = 15;

   // d = D_YEAR*c + c/4; g = b - d stays within 123..488
   localparam int D_W    = B_W;
   localparam int D_YEAR = 365;
   localparam int G_W    = 9;

   // e = (E_SCALE*g) / E_DIV; the scale is folded into the reciprocal
   localparam int     E_X_W    = 23;
   localparam longint E_DIV    = 306001;
   localparam longint E_SCALE  = 10000;
   localparam int     E_SHIFT  = E_X_W + $clog2(E_DIV);
   localparam int     E_MUL_W  = E_SHIFT - $clog2(E_DIV) + 1;
   localparam longint E_MUL    = ((longint'(1) << E_SHIFT) + E_DIV - 1) / E_DIV;
   localparam int     E_KMUL_W = E_MUL_W + $clog2(E_SCALE);
   localparam logic [E_KMUL_W-1:0] E_KMUL_V = E_KMUL_W'(E_MUL * E_SCALE);
   localparam int     E_P_W    = G_W + E_KMUL_W;
   localparam int     E_W      = 4;

   // floor(30.6001*e): day offset of the start of month index e
   localparam logic [G_W-1:0] MONTH_OFFSET [2**E_W] = '{
      9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
      9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
   };

   // Month and year fixups
   localparam logic [E_W-1:0]     MONTH_WRAP_E = 4'd13;
   localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd2;
   localparam int                 YEAR_CALC_W  = C_W + 1;
   localparam int                 YEAR_BASE    = 4715;

   // Stage payloads
   typedef struct packed {
      logic [JD_W-1:0]      jd;
      logic                 greg;
      logic [ALPHA_X_W-1:0] x;
   } jdcal_s1_type;

   typedef struct packed {
      logic [JD_W-1:0]      jd;
      logic                 greg;
      logic [ALPHA_P_W-1:0] prod;
   } jdcal_s2_type;

   typedef struct packed {
      logic [B_W-1:0] b;
      logic [Y_W-1:0] y;
   } jdcal_front_type;

   typedef struct packed {
      logic [B_W-1:0]   b;
      logic [C_P_W-1:0] prod;
   } jdcal_s4_type;

   typedef struct packed {
      logic [C_W-1:0] c;
      logic [G_W-1:0] g;
   } jdcal_mid_type;

   typedef struct packed {
      logic [C_W-1:0]   c;
      logic [G_W-1:0]   g;
      logic [E_P_W-1:0] prod;
   } jdcal_s6_type;

   typedef struct packed {
      logic signed [YEAR_W-1:0] year;
      logic [MONTH_W-1:0]       month;
      logic [DAY_W-1:0]         day;
   } jdcal_result_type;

endpackage

### hdl/jdcal_if.sv
// ----------------------------------------------------------------------------
// jdcal_req_if / jdcal_rsp_if: valid/ready channels of the converter
// Request carries a day number, response carries year, month and day.
// ----------------------------------------------------------------------------
interface jdcal_req_if;
   import jdcal_pkg::*;

   logic            valid;
   logic            ready;
   logic [JD_W-1:0] julian_day;

   modport source (output valid, output julian_day, input ready);
   modport sink   (input valid, input julian_day, output ready);
endinterface

interface jdcal_rsp_if;
   import jdcal_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [YEAR_W-1:0] year;
   logic [MONTH_W-1:0]       month;
   logic [DAY_W-1:0]         day;

   modport source (output valid, output year, output month, output day, input ready);
   modport sink   (input valid, input year, input month, input day, output ready);
endinterface

### hdl/date_from_julian_day_top.sv
// ----------------------------------------------------------------------------
// date_from_julian_day_top: Julian Day Number to calendar date
// Seven-stage pipeline turning a day number into year, month and day.
// ----------------------------------------------------------------------------
// Each request transaction carries one Julian Day Number (0..5373484 is the
// intended range; larger 23-bit values still give a valid month and day, and
// the year wraps in 15 bits past 16383). Day numbers from 2299161 on use the
// Gregorian calendar, earlier ones the Julian calendar, and there is no year
// zero: 1 BC comes out as -1. Every request produces exactly one response
// transaction, in order. The block takes one transaction per clock while the
// response side is not stalling. The three reciprocal multipliers (alpha,
// whole years, month index) set the pipeline depth: each has a register in
// front and behind, and the output register adds the last stage. There is no
// state between transactions, and reset only clears the stage valid bits. A
// stall on the response side holds the pipeline from the output backward;
// empty stages keep filling, so up to seven transactions can be in flight
// while a response waits.
// ----------------------------------------------------------------------------
module date_from_julian_day_top (
   input  logic        clock,
   input  logic        reset,
   jdcal_req_if.sink   req_chan,
   jdcal_rsp_if.source rsp_chan
);
   import jdcal_pkg::*;

   logic             front_valid, front_ready;
   jdcal_front_type  front_data;
   logic             mid_valid, mid_ready;
   jdcal_mid_type    mid_data;
   jdcal_result_type result;

   // Stages 1-3: century correction, then scale for the year division
   jdcal_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_jd     (req_chan.julian_day),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // Stages 4-5: split into whole years and the day count inside the year
   jdcal_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   // Stages 6-7: month index, then the output register holding the date
   jdcal_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (result)
   );

   // Drive the response payload straight from the output register
   assign rsp_chan.year  = result.year;
   assign rsp_chan.month = result.month;
   assign rsp_chan.day   = result.day;

endmodule

### hdl/jdcal_front.sv
// ----------------------------------------------------------------------------
// jdcal_front: stages 1 to 3 of the converter
// Gregorian century correction (alpha) and the scaled year dividend y.
// ----------------------------------------------------------------------------
module jdcal_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [jdcal_pkg::JD_W-1:0]  in_jd,
   output logic                        out_valid,
   input  logic                        out_ready,
   output jdcal_pkg::jdcal_front_type  out_data
);
   import jdcal_pkg::*;

   jdcal_s1_type    s1_in, s1_ff;
   jdcal_s2_type    s2_in, s2_ff;
   jdcal_front_type s3_in, s3_ff;
   logic            s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic            s1_en, s2_en, s3_en;
   logic [ALPHA_W-1:0] alpha;
   logic [B_W-1:0]     alpha_ext;
   logic [B_W-1:0]     a_val;
   logic [Y_FULL_W-1:0] y_full;

   // Advance a stage when it is empty or its successor advances
   assign s3_en    = !s3_vld_ff || out_ready;
   assign s2_en    = !s2_vld_ff || s3_en;
   assign s1_en    = !s1_vld_ff || s2_en;
   assign in_ready = s1_en;

   always_comb begin
      s1_in.jd   = in_jd;
      s1_in.greg = (in_jd >= GREG_START);
      s1_in.x    = {in_jd, 2'b00} - ALPHA_BIAS;
   end

   always_comb begin
      s2_in.jd   = s1_ff.jd;
      s2_in.greg = s1_ff.greg;
      s2_in.prod = {{ALPHA_MUL_W{1'b0}}, s1_ff.x} * {{ALPHA_X_W{1'b0}}, ALPHA_MUL_V};
   end

   always_comb begin
      alpha     = s2_ff.prod[ALPHA_SHIFT +: ALPHA_W];
      alpha_ext = B_W'(alpha);
      if (s2_ff.greg) begin
         a_val = B_W'(s2_ff.jd) + B_W'(1) + alpha_ext - (alpha_ext >> 2);
      end else begin
         a_val = B_W'(s2_ff.jd);
      end
      s3_in.b = a_val + B_W'(B_OFFSET);
      y_full  = Y_FULL_W'(s3_in.b) * Y_FULL_W'(Y_SCALE) - Y_FULL_W'(Y_OFFSET);
      s3_in.y = y_full[Y_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (s1_en) s1_vld_ff <= in_valid;
         if (s2_en) s2_vld_ff <= s1_vld_ff;
         if (s3_en) s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) s1_ff <= s1_in;
      if (s2_en) s2_ff <= s2_in;
      if (s3_en) s3_ff <= s3_in;
   end

   assign out_valid = s3_vld_ff;
   assign out_data  = s3_ff;

endmodule

### hdl/jdcal_split.sv
// ----------------------------------------------------------------------------
// jdcal_split: stages 4 and 5 of the converter
// Whole Julian years c and the day count g left within the shifted year.
// ----------------------------------------------------------------------------
module jdcal_split (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  jdcal_pkg::jdcal_front_type in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output jdcal_pkg::jdcal_mid_type   out_data
);
   import jdcal_pkg::*;

   jdcal_s4_type  s4_in, s4_ff;
   jdcal_mid_type s5_in, s5_ff;
   logic          s4_vld_ff, s5_vld_ff;
   logic          s4_en, s5_en;
   logic [C_W-1:0] c_val;
   logic [D_W-1:0] d_val;
   logic [B_W-1:0] g_full;

   assign s5_en    = !s5_vld_ff || out_ready;
   assign s4_en    = !s4_vld_ff || s5_en;
   assign in_ready = s4_en;

   always_comb begin
      s4_in.b    = in_data.b;
      s4_in.prod = {{C_MUL_W{1'b0}}, in_data.y} * {{Y_W{1'b0}}, C_MUL_V};
   end

   always_comb begin
      c_val   = s4_ff.prod[C_SHIFT +: C_W];
      d_val   = D_W'(c_val) * D_W'(D_YEAR) + D_W'(c_val >> 2);
      g_full  = s4_ff.b - d_val;
      s5_in.c = c_val;
      s5_in.g = g_full[G_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         if (s4_en) s4_vld_ff <= in_valid;
         if (s5_en) s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_en) s4_ff <= s4_in;
      if (s5_en) s5_ff <= s5_in;
   end

   assign out_valid = s5_vld_ff;
   assign out_data  = s5_ff;

endmodule

### hdl/jdcal_back.sv
// ----------------------------------------------------------------------------
// jdcal_back: stages 6 and 7 of the converter
// Month index e, then day, month and civil year into the output register.
// ----------------------------------------------------------------------------
module jdcal_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  jdcal_pkg::jdcal_mid_type    in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output jdcal_pkg::jdcal_result_type out_data
);
   import jdcal_pkg::*;

   jdcal_s6_type     s6_in, s6_ff;
   jdcal_result_type s7_in, s7_ff;
   logic             s6_vld_ff, s7_vld_ff;
   logic             s6_en, s7_en;
   logic [E_W-1:0]         e_val;
   logic [G_W-1:0]         day_full;
   logic [MONTH_W-1:0]     month_val;
   logic [YEAR_CALC_W-1:0] year_a;
   logic [YEAR_CALC_W-1:0] year_b;
   logic [YEAR_CALC_W-1:0] year_c;

   assign s7_en    = !s7_vld_ff || out_ready;
   assign s6_en    = !s6_vld_ff || s7_en;
   assign in_ready = s6_en;

   always_comb begin
      s6_in.c    = in_data.c;
      s6_in.g    = in_data.g;
      s6_in.prod = {{E_KMUL_W{1'b0}}, in_data.g} * {{G_W{1'b0}}, E_KMUL_V};
   end

   always_comb begin
      e_val    = s6_ff.prod[E_SHIFT +: E_W];
      day_full = s6_ff.g - MONTH_OFFSET[e_val];

      // March-based month index folds back to January and February
      if (e_val > MONTH_WRAP_E) begin
         month_val = e_val - MONTH_WRAP_E;
      end else begin
         month_val = e_val - E_W'(1);
      end

      year_a = {1'b0, s6_ff.c} - YEAR_CALC_W'(YEAR_BASE);
      year_b = (month_val > FEBRUARY) ? year_a - YEAR_CALC_W'(1) : year_a;
      // Skip year zero
      year_c = ($signed(year_b) <= 0) ? year_b - YEAR_CALC_W'(1) : year_b;

      s7_in.year  = $signed(year_c[YEAR_W-1:0]);
      s7_in.month = month_val;
      s7_in.day   = day_full[DAY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else begin
         if (s6_en) s6_vld_ff <= in_valid;
         if (s7_en) s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s6_en) s6_ff <= s6_in;
      if (s7_en) s7_ff <= s7_in;
   end

   assign out_valid = s7_vld_ff;
   assign out_data  = s7_ff;

endmodule

### tb/date_from_julian_day_top_test.sv
// ----------------------------------------------------------------------------
// date_from_julian_day_top_test: self-checking bench for the day-number converter
// Streams directed and random Julian Day Numbers through the pipeline with
// random gaps and stalls on both channels. Each date is predicted in integer
// arithmetic and checked field by field against the response stream, in order.
// ----------------------------------------------------------------------------
module date_from_julian_day_top_test;
   import jdcal_pkg::*;

   // Day-number limits and the length of the random part
   localparam logic [JD_W-1:0] LAST_VALID_DAY = 23'd5373484;
   localparam logic [JD_W-1:0] LARGEST_DAY    = 23'h7FFFFF;
   localparam int              FIRST_GREG_DAY = 2299161;
   localparam int              RANDOM_DAYS    = 500;
   // Cycles without any accepted transaction before the run is abandoned
   localparam int              IDLE_LIMIT     = 1000;
   // Long receiver hold-off: when it starts and how long it lasts
   localparam int              HOLD_AT_RSP    = 150;
   localparam int              HOLD_CYCLES    = 60;
   // Cycles to wait after the last response, comfortably past the pipe depth
   localparam int              DRAIN_CYCLES   = 16;

   logic clock = 1'b0;
   logic reset;

   jdcal_req_if req_chan ();
   jdcal_rsp_if rsp_chan ();

   date_from_julian_day_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Date prediction. Every quantity below is non-negative for a 23-bit day
   // number, so integer division here truncates exactly as the spec asks.
   // -------------------------------------------------------------------------
   function automatic jdcal_result_type predict_calendar_date(logic [JD_W-1:0] jd);
      longint           day_num, shifted, alpha, base_day, whole_years, year_days;
      longint           month_idx, dom, mon, yr;
      jdcal_result_type date;
      day_num = longint'(jd);
      // Gregorian dates skip the dropped century leap days
      if (day_num < FIRST_GREG_DAY) begin
         shifted = day_num;
      end else begin
         alpha   = (4 * day_num - 7468865) / 146097;
         shifted = day_num + 1 + alpha - alpha / 4;
      end
      base_day    = shifted + 1524;
      whole_years = (100 * base_day - 12210) / 36525;
      year_days   = 365 * whole_years + whole_years / 4;
      month_idx   = (10000 * (base_day - year_days)) / 306001;
      dom         = base_day - year_days - (306001 * month_idx) / 10000;
      mon         = month_idx - 1;
      if (mon > 12) begin
         mon = mon - 12;
      end
      yr = whole_years - 4715;
      if (mon > 2) begin
         yr = yr - 1;
      end
      // No year zero: shift every BC year down by one
      if (yr <= 0) begin
         yr = yr - 1;
      end
      // Above the nominal range the year simply wraps in its 15 bits
      date.year  = YEAR_W'(yr);
      date.month = MONTH_W'(mon);
      date.day   = DAY_W'(dom);
      return date;
   endfunction

   // -------------------------------------------------------------------------
   // Scoreboard: queue of predicted dates, oldest first
   // -------------------------------------------------------------------------
   class date_scoreboard;
      jdcal_result_type pending_dates[$];
      int               errors = 0;

      function void note_day(logic [JD_W-1:0] jd);
         pending_dates.push_back(predict_calendar_date(jd));
      endfunction

      function void check_date(logic signed [YEAR_W-1:0] year, logic [MONTH_W-1:0] month,
                               logic [DAY_W-1:0] day);
         jdcal_result_type want;
         if (pending_dates.size() == 0) begin
            $error("unexpected response: year %0d month %0d day %0d", year, month, day);
            errors++;
            return;
         end
         want = pending_dates.pop_front();
         if (want.year !== year) begin
            $error("year: expected %0d, got %0d", want.year, year);
            errors++;
         end
         if (want.month !== month) begin
            $error("month: expected %0d, got %0d", want.month, month);
            errors++;
         end
         if (want.day !== day) begin
            $error("day: expected %0d, got %0d", want.day, day);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_dates.size();
      endfunction
   endclass

   date_scoreboard dates = new();
   int             days_sent = 0;

   // -------------------------------------------------------------------------
   // Request side: offer one day number and hold it until accepted. Valid is
   // only lowered when a gap is drawn, so back-to-back transactions keep it
   // high without a second assignment in the same step. Every fourth run of
   // 32 transactions goes without gaps.
   // -------------------------------------------------------------------------
   task automatic send_day(input logic [JD_W-1:0] jd);
      int gap;
      gap = (((days_sent / 32) % 4) == 3) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.julian_day <= jd;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      dates.note_day(jd);
      days_sent++;
   endtask

   // Pick a day number: mostly the nominal range, with weight on the calendar
   // switch, the turn of the era, and values beyond the range up to all ones.
   function automatic logic [JD_W-1:0] draw_day();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            return JD_W'(FIRST_GREG_DAY - 400 + $urandom_range(0, 800));
         end
         1: begin
            return JD_W'(1721424 - 800 + $urandom_range(0, 1600));
         end
         2: begin
            return JD_W'($urandom);
         end
         3: begin
            return JD_W'($urandom_range(int'(LAST_VALID_DAY) + 1, int'(LARGEST_DAY)));
         end
         default: begin
            return JD_W'($urandom_range(0, int'(LAST_VALID_DAY)));
         end
      endcase
   endfunction

   // Directed day numbers
   localparam int DIRECTED_DAYS = 24;
   localparam logic [JD_W-1:0] DIRECTED [DIRECTED_DAYS] = '{
      23'd0,        // first day of the count, 4713 BC
      23'd1,
      23'd1721057,  // around the leap day of 1 BC
      23'd1721118,
      23'd1721423,  // last day BC
      23'd1721424,  // first day AD, no year zero between
      23'd2299159,  // last Julian days
      23'd2299160,
      23'd2299161,  // first Gregorian day
      23'd2299162,
      23'd2415079,  // 1900 is not a Gregorian leap year
      23'd2415080,
      23'd2451603,  // 2000 is
      23'd2451604,
      23'd2451545,
      23'd4194303,  // top input bit flips
      23'd4194304,
      23'd5373483,
      23'd5373484,  // last nominal day
      23'd5373485,  // first day above range
      23'd7705000,  // year crosses 16383 and wraps
      23'd7706000,
      23'h555555,
      23'h7FFFFF    // largest 23-bit day number
   };

   // -------------------------------------------------------------------------
   // Response side: draw a stall per transaction, then wait for valid with
   // ready high. One run of 40 transactions in every three goes without stalls.
   // Once, drop ready for a long stretch so the pipe fills and backs up
   // into the request channel while the sender keeps offering.
   // -------------------------------------------------------------------------
   initial begin : response_side
      int seen;
      int stall;
      seen = 0;
      @(negedge reset);
      forever begin
         stall = (((seen / 40) % 3) == 1) ? 0 : $urandom_range(0, 4);
         if (seen == HOLD_AT_RSP) begin
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_chan.valid);
         dates.check_date(rsp_chan.year, rsp_chan.month, rsp_chan.day);
         seen++;
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: count cycles in which neither channel moves a transaction
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int idle;
      idle = 0;
      @(negedge reset);
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("date_from_julian_day_top_test: errors");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence: reset, directed days, random days, drain, verdict
   // -------------------------------------------------------------------------
   initial begin : main_sequence
      // Hold every input at a known value through reset
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.julian_day <= '0;
      rsp_chan.ready      <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         send_day(DIRECTED[i]);
      end
      repeat (RANDOM_DAYS) begin
         send_day(draw_day());
      end
      // Last transaction accepted: drop valid once
      req_chan.valid <= 1'b0;

      // Wait for every predicted date, then wait out DRAIN_CYCLES for strays
      while (dates.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (dates.errors == 0 && dates.outstanding() == 0) begin
         $display("date_from_julian_day_top_test: clean");
      end else begin
         $display("date_from_julian_day_top_test: errors");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/jdcal_pkg.sv
hdl/jdcal_if.sv
hdl/jdcal_front.sv
hdl/jdcal_split.sv
hdl/jdcal_back.sv
hdl/date_from_julian_day_top.sv
tb/date_from_julian_day_top_test.sv
